/* sv/ffba_pkg.sv */
// Package: shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int unsigned FW = 17;          // field width of sizes and offsets
    localparam int unsigned HW = 7;           // header register width
    localparam logic [HW-1:0] HDR_RESET = 7'd24;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADADDR = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        FIT_NONE  = 2'd0,
        FIT_EXACT = 2'd1,
        FIT_SPLIT = 2'd2
    } fit_t;

    typedef enum logic [1:0]
    {
        OP_NONE  = 2'd0,
        OP_EXACT = 2'd1,
        OP_SPLIT = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_APPLY = 2'd2
    } state_t;

    // search record travelling down the chain of cells
    typedef struct packed
    {
        logic          v;
        logic          found;
        fit_t          kind;
        logic          pf;      // block before the hit is free
        logic          nf;      // block after the hit is free
        logic [FW-1:0] offset;
    } rec_t;

    // update broadcast to all cells once the search is complete
    typedef struct packed
    {
        op_t  op;
        logic pf;
        logic nf;
    } apply_t;

endpackage
`default_nettype wire

/* sv/ffba_if.sv */
// Interfaces: request, response and configuration channels of the allocator.
`default_nettype none
interface ffba_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [ffba_pkg::FW-1:0]  request_bytes;
    logic [ffba_pkg::FW-1:0]  address;
    modport source (output valid, output cmd, output request_bytes, output address,
                    input ready);
    modport sink (input valid, input cmd, input request_bytes, input address,
                  output ready);
endinterface

interface ffba_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [ffba_pkg::FW-1:0]  payload_offset;
    logic [1:0]               status;
    modport source (output valid, output payload_offset, output status, input ready);
    modport sink (input valid, input payload_offset, input status, output ready);
endinterface

interface ffba_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ffba_pkg::HW-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/ffba_cell.sv */
// Cell: one table entry, its search step and its share of the insert/remove shift.
`default_nettype none
module ffba_cell #(
    parameter int AW         = 18,
    parameter bit INIT_VALID = 1'b0,
    parameter int INIT_SIZE  = 0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [ffba_pkg::HW-1:0]  hdr,
    input  wire logic                     cmd,
    input  wire logic [ffba_pkg::FW-1:0]  req_bytes,
    input  wire logic [ffba_pkg::FW-1:0]  addr,
    input  wire ffba_pkg::rec_t           rec_in,
    output ffba_pkg::rec_t                rec_out,
    input  wire ffba_pkg::apply_t         apply,
    input  wire logic [2*AW+1:0]          prev_ent,
    input  wire logic [2*AW+1:0]          next_ent,
    input  wire logic [2*AW+1:0]          next2_ent,
    input  wire logic                     prev_hit,
    input  wire logic                     next_hit,
    output logic [2*AW+1:0]               ent,
    output logic                          hit
);
    import ffba_pkg::*;

    logic          v_reg, v_next, free_reg, free_next;
    logic [AW-1:0] start_reg, start_next, size_reg, size_next;
    logic          hit_reg, after_reg;
    rec_t          rec_reg, rec_next;

    logic          pv, pfr, nv, nfr;
    logic [AW-1:0] ps, psz, nsz, n2sz;
    logic [AW-1:0] hdr_w, req_w, pay_addr, sum1, sum2;
    logic          fit, match, hit_now;
    logic [2*AW+1:0] sel_ent;

    assign {pv, pfr, ps, psz} = prev_ent;
    assign nv                 = next_ent[2*AW+1];
    assign nfr                = next_ent[2*AW];
    assign nsz                = next_ent[AW-1:0];
    assign n2sz               = next2_ent[AW-1:0];

    assign hdr_w    = AW'(hdr);
    assign req_w    = AW'(req_bytes);
    assign pay_addr = start_reg + hdr_w;
    assign fit      = v_reg && free_reg && (size_reg >= req_w);
    assign match    = v_reg && (pay_addr == AW'(addr));
    assign hit_now  = rec_in.v && !rec_in.found && ((cmd == CMD_ALLOC) ? fit : match);
    assign sum1     = size_reg + hdr_w + nsz;
    assign sum2     = sum1 + (apply.nf ? (hdr_w + n2sz) : '0);
    assign sel_ent  = (apply.pf && apply.nf) ? next2_ent : next_ent;

    // search step
    always_comb
    begin
        rec_next = rec_in;
        if (hit_now)
        begin
            rec_next.found  = 1'b1;
            rec_next.offset = pay_addr[FW-1:0];
            rec_next.pf     = pv && pfr;
            rec_next.nf     = nv && nfr;
            if (size_reg == req_w)
                rec_next.kind = FIT_EXACT;
            else if (size_reg > req_w + hdr_w)
                rec_next.kind = FIT_SPLIT;
            else
                rec_next.kind = FIT_NONE;
        end
    end

    // table update
    always_comb
    begin
        v_next     = v_reg;
        free_next  = free_reg;
        start_next = start_reg;
        size_next  = size_reg;
        case (apply.op)
            OP_EXACT:
            begin
                if (hit_reg)
                    free_next = 1'b0;
            end
            OP_SPLIT:
            begin
                if (hit_reg)
                begin
                    size_next = req_w;
                    free_next = 1'b0;
                end
                else if (prev_hit)
                begin
                    v_next     = 1'b1;
                    free_next  = 1'b1;
                    start_next = ps + hdr_w + req_w;
                    size_next  = psz - req_w - hdr_w;
                end
                else if (after_reg)
                begin
                    {v_next, free_next, start_next, size_next} = prev_ent;
                end
            end
            OP_FREE:
            begin
                if (next_hit && apply.pf)
                    size_next = sum2;
                else if (hit_reg && !apply.pf)
                begin
                    free_next = 1'b1;
                    if (apply.nf)
                        size_next = sum1;
                end
                else if ((hit_reg || after_reg) && (apply.pf || apply.nf))
                begin
                    {v_next, free_next, start_next, size_next} = sel_ent;
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= INIT_VALID;
            free_reg  <= INIT_VALID;
            start_reg <= '0;
            size_reg  <= AW'(INIT_SIZE);
            rec_reg   <= '0;
            hit_reg   <= 1'b0;
            after_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= v_next;
            free_reg  <= free_next;
            start_reg <= start_next;
            size_reg  <= size_next;
            rec_reg   <= rec_next;
            if (rec_in.v)
            begin
                hit_reg   <= hit_now;
                after_reg <= rec_in.found;
            end
        end
    end

    assign rec_out = rec_reg;
    assign ent     = {v_reg, free_reg, start_reg, size_reg};
    assign hit     = hit_reg;

endmodule
`default_nettype wire

/* sv/first_fit_block_allocator_top.sv */
// Top level: first-fit block allocator with a chain of table cells and its controller.
// Flow: an accepted request is launched into the first cell by a registered strobe, crosses
//   the cell chain, has its search result captured as it leaves the last cell, and then
//   updates the table while its response is registered, once the response register is free.
// Requests: one at a time; a new request is accepted only in idle, after the previous one
//   has updated the table, and a response that is not taken can stall that update.
// Reset: the table holds one free block at offset zero spanning the region, header 24.
`default_nettype none
module first_fit_block_allocator_top #(
    parameter int REGION_BYTES = 65536,
    parameter int MAX_BLOCKS   = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp,
    ffba_cfg_if.sink   cfg
);
    import ffba_pkg::*;

    // room for sizes and starts, including header growth from later merges
    localparam int AW0 = $clog2(REGION_BYTES + 128 * MAX_BLOCKS) + 1;
    localparam int AW  = (AW0 > 18) ? AW0 : 18;
    localparam int EW  = 2 * AW + 2;
    localparam int CW  = $clog2(MAX_BLOCKS + 1);

    state_t          state_reg, state_next;
    logic [HW-1:0]   hdr_reg;
    logic            cmd_reg;
    logic [FW-1:0]   reqb_reg, addr_reg;
    logic            inject_reg;
    logic [CW-1:0]   count_reg, count_next;
    rec_t            res_reg;
    logic            out_v_reg;
    logic [FW-1:0]   out_off_reg, off_next;
    status_t         out_st_reg, st_next;
    logic            accept, apply_go, rec_exit;
    apply_t          apply;

    rec_t            rec_w [0:MAX_BLOCKS];
    logic [EW-1:0]   ent_ext [0:MAX_BLOCKS+2];
    logic            hit_ext [0:MAX_BLOCKS+1];
    logic [MAX_BLOCKS-1:0] rec_v_vec;

    assign accept   = req.valid && req.ready;
    assign rec_exit = rec_w[MAX_BLOCKS].v;

    // launch the search record in the cycle after capture so the request fields are stable
    always_comb
    begin
        rec_w[0]   = '0;
        rec_w[0].v = inject_reg;
    end

    // pad the chain ends with empty entries
    assign ent_ext[0]            = '0;
    assign ent_ext[MAX_BLOCKS+1] = '0;
    assign ent_ext[MAX_BLOCKS+2] = '0;
    assign hit_ext[0]            = 1'b0;
    assign hit_ext[MAX_BLOCKS+1] = 1'b0;

    for (genvar j = 0; j < MAX_BLOCKS; j++)
    begin : g_cell
        ffba_cell #(
            .AW         (AW),
            .INIT_VALID ((j == 0) ? 1'b1 : 1'b0),
            .INIT_SIZE  ((j == 0) ? (REGION_BYTES - int'(HDR_RESET)) : 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .hdr       (hdr_reg),
            .cmd       (cmd_reg),
            .req_bytes (reqb_reg),
            .addr      (addr_reg),
            .rec_in    (rec_w[j]),
            .rec_out   (rec_w[j+1]),
            .apply     (apply),
            .prev_ent  (ent_ext[j]),
            .next_ent  (ent_ext[j+2]),
            .next2_ent (ent_ext[j+3]),
            .prev_hit  (hit_ext[j]),
            .next_hit  (hit_ext[j+2]),
            .ent       (ent_ext[j+1]),
            .hit       (hit_ext[j+1])
        );
        assign rec_v_vec[j] = rec_w[j+1].v;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rec_exit)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_go)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the controller: decide the table update and the response
    always_comb
    begin
        req.ready  = (state_reg == S_IDLE);
        apply_go   = (state_reg == S_APPLY) && (!out_v_reg || rsp.ready);
        apply      = '0;
        apply.op   = OP_NONE;
        st_next    = ST_OK;
        off_next   = '0;
        count_next = count_reg;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (!res_reg.found || res_reg.kind == FIT_NONE)
                st_next = ST_NOSPACE;
            else if (res_reg.kind == FIT_EXACT)
            begin
                apply.op = OP_EXACT;
                off_next = res_reg.offset;
            end
            else if (count_reg >= CW'(MAX_BLOCKS))
                st_next = ST_FULL;
            else
            begin
                apply.op   = OP_SPLIT;
                off_next   = res_reg.offset;
                count_next = count_reg + 1'b1;
            end
        end
        else if (res_reg.found)
        begin
            apply.op   = OP_FREE;
            apply.pf   = res_reg.pf;
            apply.nf   = res_reg.nf;
            count_next = count_reg - CW'(res_reg.pf) - CW'(res_reg.nf);
        end
        else
            st_next = ST_BADADDR;
        // hold the table unless the response register can take the result
        if (!apply_go)
        begin
            apply.op   = OP_NONE;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hdr_reg    <= HDR_RESET;
            inject_reg <= 1'b0;
            count_reg  <= CW'(1);
            out_v_reg  <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept;
            count_reg  <= count_next;
            if (cfg.valid && cfg.ready)
                hdr_reg <= cfg.data;
            // capture the search result as it leaves the last cell
            if (rec_exit)
                res_reg <= rec_w[MAX_BLOCKS];
            if (apply_go)
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;
        end
    end

    // payload registers: request fields and response fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.cmd;
            reqb_reg <= req.request_bytes;
            addr_reg <= req.address;
        end
        if (apply_go)
        begin
            out_off_reg <= off_next;
            out_st_reg  <= st_next;
        end
    end

    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_v_reg;
    assign rsp.payload_offset = out_off_reg;
    assign rsp.status         = out_st_reg;

    // the block table never holds more entries than there are cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count exceeds cell count");

    // at most one search record is in flight in the chain
    a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rec_v_vec))
        else $error("more than one search record in the chain");

    // a record leaves the chain only while a search is running
    a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rec_exit |-> (state_reg == S_SCAN))
        else $error("search record left the chain outside a search");

    // an accepted request launches exactly one record next cycle
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (inject_reg && state_reg == S_SCAN))
        else $error("accepted request did not launch a search");

endmodule
`default_nettype wire
